>>> src/pop3c_pkg.sv
package pop3c_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned WORD_CHARS = 4;
   localparam int unsigned WORD_W = BYTE_W * WORD_CHARS;
   localparam int unsigned LEN_W = 3;

   localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;
   localparam logic [BYTE_W-1:0] WORD_LO = "0";
   localparam logic [BYTE_W-1:0] WORD_HI = "z";
   localparam logic [BYTE_W-1:0] UPPER_LO = "A";
   localparam logic [BYTE_W-1:0] UPPER_HI = "Z";
   localparam logic [BYTE_W-1:0] CASE_BIT = 8'h20;

   typedef enum logic [1:0] {
      CLASS_MULTI  = 2'd0,
      CLASS_SINGLE = 2'd1,
      CLASS_RETR   = 2'd2,
      CLASS_UNKNOWN = 2'd3
   } class_type;

   typedef struct packed {
      logic [WORD_W-1:0] chars;
      logic [LEN_W-1:0]  length;
      logic              too_long;
   } word_type;

   // first character lands in the low byte
   function automatic logic [WORD_W-1:0] pack4(input logic [BYTE_W-1:0] c0,
                                                input logic [BYTE_W-1:0] c1,
                                                input logic [BYTE_W-1:0] c2,
                                                input logic [BYTE_W-1:0] c3);
      pack4 = {c3, c2, c1, c0};
   endfunction

   localparam logic [WORD_W-1:0] WORD_LIST = pack4("l", "i", "s", "t");
   localparam logic [WORD_W-1:0] WORD_UIDL = pack4("u", "i", "d", "l");
   localparam logic [WORD_W-1:0] WORD_TOP  = pack4("t", "o", "p", 8'h00);
   localparam logic [WORD_W-1:0] WORD_USER = pack4("u", "s", "e", "r");
   localparam logic [WORD_W-1:0] WORD_PASS = pack4("p", "a", "s", "s");
   localparam logic [WORD_W-1:0] WORD_STAT = pack4("s", "t", "a", "t");
   localparam logic [WORD_W-1:0] WORD_DELE = pack4("d", "e", "l", "e");
   localparam logic [WORD_W-1:0] WORD_RSET = pack4("r", "s", "e", "t");
   localparam logic [WORD_W-1:0] WORD_QUIT = pack4("q", "u", "i", "t");
   localparam logic [WORD_W-1:0] WORD_RETR = pack4("r", "e", "t", "r");

endpackage

>>> src/pop3c_classify.sv
module pop3c_classify (
   input  pop3c_pkg::word_type  word,
   output pop3c_pkg::class_type word_class
);

   always_comb begin
      word_class = pop3c_pkg::CLASS_UNKNOWN;
      if (word.too_long || word.length == 3'd0) begin
         word_class = pop3c_pkg::CLASS_UNKNOWN;
      end else if (word.length == 3'd3) begin
         if (word.chars == pop3c_pkg::WORD_TOP) begin
            word_class = pop3c_pkg::CLASS_MULTI;
         end
      end else if (word.length == 3'd4) begin
         if (word.chars == pop3c_pkg::WORD_LIST || word.chars == pop3c_pkg::WORD_UIDL) begin
            word_class = pop3c_pkg::CLASS_MULTI;
         end else if (word.chars == pop3c_pkg::WORD_USER ||
                      word.chars == pop3c_pkg::WORD_PASS ||
                      word.chars == pop3c_pkg::WORD_STAT ||
                      word.chars == pop3c_pkg::WORD_DELE ||
                      word.chars == pop3c_pkg::WORD_RSET ||
                      word.chars == pop3c_pkg::WORD_QUIT) begin
            word_class = pop3c_pkg::CLASS_SINGLE;
         end else if (word.chars == pop3c_pkg::WORD_RETR) begin
            word_class = pop3c_pkg::CLASS_RETR;
         end
      end
   end

endmodule

>>> src/pop3c_line_tracker.sv
module pop3c_line_tracker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [pop3c_pkg::BYTE_W-1:0]  byte_in,
   output logic                          line_done,
   output pop3c_pkg::class_type          line_class
);

   typedef enum logic [1:0] {
      PHASE_BEFORE = 2'd0,
      PHASE_INSIDE = 2'd1,
      PHASE_AFTER  = 2'd2
   } phase_type;

   logic                 cr_seen_ff, cr_seen_in;
   phase_type            phase_ff, phase_in;
   pop3c_pkg::word_type  word_ff, word_in;
   pop3c_pkg::class_type word_class;
   logic                 in_range;
   logic                 take_char;
   logic [pop3c_pkg::BYTE_W-1:0] folded;

   pop3c_classify u_classify (
      .word       (word_ff),
      .word_class (word_class)
   );

   assign in_range = (byte_in >= pop3c_pkg::WORD_LO) && (byte_in <= pop3c_pkg::WORD_HI);
   assign folded = (byte_in >= pop3c_pkg::UPPER_LO && byte_in <= pop3c_pkg::UPPER_HI) ?
                   (byte_in | pop3c_pkg::CASE_BIT) : byte_in;
   assign line_done = cr_seen_ff && (byte_in == pop3c_pkg::CHAR_LF);
   assign line_class = line_done ? word_class : pop3c_pkg::class_type'(2'd0);

   always_comb begin
      cr_seen_in = cr_seen_ff;
      phase_in = phase_ff;
      word_in = word_ff;
      take_char = 1'b0;
      if (line_done) begin
         cr_seen_in = 1'b0;
         phase_in = PHASE_BEFORE;
         word_in = '0;
      end else begin
         cr_seen_in = (byte_in == pop3c_pkg::CHAR_CR);
         // NUL bytes never reach the word
         if (byte_in != pop3c_pkg::CHAR_NUL) begin
            unique case (phase_ff)
               PHASE_BEFORE: begin
                  if (in_range) begin
                     phase_in = PHASE_INSIDE;
                     take_char = 1'b1;
                  end
               end
               PHASE_INSIDE: begin
                  if (in_range) begin
                     take_char = 1'b1;
                  end else begin
                     phase_in = PHASE_AFTER;
                  end
               end
               default: begin
               end
            endcase
         end
         if (take_char) begin
            if (word_ff.length < 3'd4) begin
               word_in.chars[{word_ff.length[1:0], 3'b000} +: pop3c_pkg::BYTE_W] = folded;
               word_in.length = word_ff.length + 3'd1;
            end else begin
               word_in.too_long = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cr_seen_ff <= 1'b0;
         phase_ff <= PHASE_BEFORE;
         word_ff <= '0;
      end else if (step) begin
         cr_seen_ff <= cr_seen_in;
         phase_ff <= phase_in;
         word_ff <= word_in;
      end
   end

endmodule

>>> src/pop3_command_line_classifier.sv
// POP3 client command line classifier.
// Request channel (req_valid/req_ready/req_byte_in) carries one command byte
// per request. Every request yields exactly one response on the rsp_ channel:
// rsp_line_done is high when the byte was the LF of a CR LF pair, and then
// rsp_command_class gives 0 multi-line (list, uidl, top), 1 single-line
// (user, pass, stat, dele, rset, quit), 2 retr or 3 unknown; otherwise the
// class reads 0. The command word is the first run of bytes in '0'..'z',
// folded to lower case; NUL bytes are ignored by the word.
// The byte lands in an input register, is processed against the line state,
// and the response sits in an output register.
// Throughput is one byte per cycle; both registers advance together whenever
// the output register is empty or being drained, so a stalled receiver holds
// the response and backs up at most one more request in the input register.
// Synchronous reset empties both registers and returns the line state to the
// start of a line (no CR seen, empty word).
module pop3_command_line_classifier (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [pop3c_pkg::BYTE_W-1:0]  req_byte_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_line_done,
   output logic [1:0]                    rsp_command_class
);

   logic                         in_valid_ff;
   logic [pop3c_pkg::BYTE_W-1:0] in_byte_ff;
   logic                         out_valid_ff;
   logic                         done_ff;
   pop3c_pkg::class_type         class_ff;
   logic                         advance;
   logic                         step;
   logic                         done_in;
   pop3c_pkg::class_type         class_in;

   assign advance = !out_valid_ff || rsp_ready;
   assign step = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   pop3c_line_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .byte_in    (in_byte_ff),
      .line_done  (done_in),
      .line_class (class_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_byte_in;
      end
      if (step) begin
         done_ff <= done_in;
         class_ff <= class_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_line_done = done_ff;
   assign rsp_command_class = class_ff;

endmodule
